// File: hdl/blm_pkg.sv
// ----------------------------------------------------------------------------
// Battery level monitor package
// Shared widths, item and state types, opcodes and the charge level table.
// ----------------------------------------------------------------------------
`default_nettype none

package blm_pkg;

    // ADC resolution used for scaling the raw samples.
    localparam int ADC_BITS = 12;

    // Field widths.
    localparam int SAMPLE_W   = 12;
    localparam int TICK_W     = 32;
    localparam int REF_W      = 13;
    localparam int INTERVAL_W = 16;
    localparam int CUR_W      = 13;
    localparam int VOLT_W     = 14;
    localparam int LEVEL_W    = 7;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Item widths on the stream ports.
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;

    // Scaling products carry one extra bit for the doubled reference.
    localparam int PROD_W = REF_W + SAMPLE_W + 1;
    localparam int SUM_W  = CUR_W + 3;

    localparam logic [CUR_W-1:0]  CUR_MAX  = '1;
    localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

    // Configuration register reset values and indexes.
    localparam logic [REF_W-1:0]      REF_MV_RESET   = REF_W'(3300);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(40);
    localparam logic [CFG_IDX_W-1:0]  REG_REF_MV        = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  REG_POLL_INTERVAL = 1'b1;

    typedef enum logic {
        OP_ADC_DONE = 1'b0,
        OP_POLL     = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [SAMPLE_W-1:0] current_sample;
        logic [SAMPLE_W-1:0] voltage_sample;
        logic [TICK_W-1:0]   tick_count;
        logic                charge_pin_level;
        logic                standby_pin_level;
    } in_item_t;

    typedef struct packed {
        logic [REF_W-1:0]      ref_mv;
        logic [INTERVAL_W-1:0] poll_interval;
    } cfg_t;

    typedef struct packed {
        logic [CUR_W-1:0]   current_avg;
        logic [VOLT_W-1:0]  voltage;
        logic [TICK_W-1:0]  next_tick;
        logic [LEVEL_W-1:0] level;
        logic               charging;
        logic               charged;
    } blm_state_t;

    typedef struct packed {
        logic [CUR_W-1:0]   current_ma;
        logic [VOLT_W-1:0]  voltage_mv;
        logic [LEVEL_W-1:0] level_pct;
        logic               charging;
        logic               charged;
        logic               start_conversion;
    } result_t;

    // Voltage thresholds in descending order with their charge levels.
    localparam int LEVEL_STEPS = 10;
    localparam logic [VOLT_W-1:0] LEVEL_MV [LEVEL_STEPS] = '{
        14'd4200, 14'd4150, 14'd4100, 14'd4000, 14'd3900,
        14'd3800, 14'd3700, 14'd3600, 14'd3500, 14'd3400
    };
    localparam logic [LEVEL_W-1:0] LEVEL_PCT [LEVEL_STEPS] = '{
        7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd50, 7'd30, 7'd20, 7'd10, 7'd5
    };

    // The first threshold that the voltage exceeds sets the level.
    function automatic logic [LEVEL_W-1:0] look_up_level(input logic [VOLT_W-1:0] mv);
        logic [LEVEL_W-1:0] pct;
        pct = '0;
        for (int i = LEVEL_STEPS - 1; i >= 0; i--)
        begin
            if (mv > LEVEL_MV[i])
            begin
                pct = LEVEL_PCT[i];
            end
        end
        return pct;
    endfunction

endpackage

`default_nettype wire

// File: hdl/blm_datapath.sv
// ----------------------------------------------------------------------------
// Battery level monitor datapath
// Computes the updated monitor state and the result for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_datapath (
    input  blm_pkg::in_item_t   item,
    input  blm_pkg::cfg_t       cfg,
    input  blm_pkg::blm_state_t state,
    output blm_pkg::blm_state_t state_next,
    output blm_pkg::result_t    result
);
    import blm_pkg::*;

    logic [PROD_W-1:0] cur_prod;
    logic [PROD_W-1:0] volt_prod;
    logic [PROD_W-1:0] cur_scaled;
    logic [PROD_W-1:0] volt_scaled;
    logic [CUR_W-1:0]  cur_sat;
    logic [VOLT_W-1:0] volt_sat;
    logic [SUM_W-1:0]  avg_sum;
    logic              poll_fire;

    // Scale both samples by the reference voltage; the voltage divider halves
    // the battery voltage, so its product uses twice the reference.
    always_comb
    begin
        cur_prod    = PROD_W'(cfg.ref_mv) * PROD_W'(item.current_sample);
        volt_prod   = PROD_W'({cfg.ref_mv, 1'b0}) * PROD_W'(item.voltage_sample);
        cur_scaled  = cur_prod >> ADC_BITS;
        volt_scaled = volt_prod >> ADC_BITS;
        cur_sat     = (cur_scaled > PROD_W'(CUR_MAX)) ? CUR_MAX : cur_scaled[CUR_W-1:0];
        volt_sat    = (volt_scaled > PROD_W'(VOLT_MAX)) ? VOLT_MAX
                                                         : volt_scaled[VOLT_W-1:0];
    end

    // Running average (avg*7 + new) / 8; the sum never exceeds the width.
    assign avg_sum = (SUM_W'({state.current_avg, 3'b000}) - SUM_W'(state.current_avg))
                   + SUM_W'(cur_sat);

    assign poll_fire = (item.opcode == OP_POLL) && (item.tick_count > state.next_tick);

    // State update per opcode.
    always_comb
    begin
        state_next = state;
        case (item.opcode)
            OP_ADC_DONE:
            begin
                state_next.current_avg = avg_sum[SUM_W-1:3];
                state_next.voltage     = volt_sat;
            end
            OP_POLL:
            begin
                state_next.charging = ~item.charge_pin_level;
                state_next.charged  = ~item.standby_pin_level;
                if (poll_fire)
                begin
                    state_next.next_tick = item.tick_count
                                         + TICK_W'(cfg.poll_interval);
                    state_next.level     = look_up_level(state.voltage);
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    // The result shows the state after the update.
    always_comb
    begin
        result.current_ma       = state_next.current_avg;
        result.voltage_mv       = state_next.voltage;
        result.level_pct        = state_next.level;
        result.charging         = state_next.charging;
        result.charged          = state_next.charged;
        result.start_conversion = poll_fire;
    end

endmodule

`default_nettype wire

// File: hdl/battery_level_monitor_unit.sv
// Path: an accepted item is held in the input register and its result item
// is offered from the result register, where it waits while the receiver stalls.
// Throughput: one item per cycle while results are taken; the input register
// and the result register let a new item enter while a finished result waits.
// Reset: asynchronous, active low; clears all monitor state and both
// stages, and loads ref_mv = 3300 and poll_interval = 40.
// ----------------------------------------------------------------------------
// Battery level monitor top level
// Stream front end with an input register, the datapath and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_monitor_unit (
    input  wire                                clk,
    input  wire                                rst_n,
    // Configuration write port.
    input  wire                                cfg_we,
    input  wire  [blm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [blm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input items.
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: current_sample[11:0], voltage_sample[23:12],
    // tick_count[55:24], charge_pin_level[56], standby_pin_level[57], zeros.
    input  wire  [blm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: opcode.
    input  wire                                s_axis_tuser,
    // Result items.
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // tdata from bit 0: current_ma[12:0], voltage_mv[26:13], level_pct[33:27],
    // charging[34], charged[35], start_conversion[36], zeros.
    output logic [blm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import blm_pkg::*;

    cfg_t       cfg_reg;
    in_item_t   item_reg;
    logic       item_valid_reg;
    blm_state_t state_reg;
    blm_state_t state_next;
    result_t    result_next;
    result_t    result_reg;
    logic       out_valid_reg;
    logic       advance;
    in_item_t   item_in;

    // Unpack the input item.
    always_comb
    begin
        item_in.opcode            = opcode_t'(s_axis_tuser);
        item_in.current_sample    = s_axis_tdata[11:0];
        item_in.voltage_sample    = s_axis_tdata[23:12];
        item_in.tick_count        = s_axis_tdata[55:24];
        item_in.charge_pin_level  = s_axis_tdata[56];
        item_in.standby_pin_level = s_axis_tdata[57];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_mv        <= REF_MV_RESET;
            cfg_reg.poll_interval <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REF_MV:        cfg_reg.ref_mv        <= cfg_data[REF_W-1:0];
                REG_POLL_INTERVAL: cfg_reg.poll_interval <= cfg_data[INTERVAL_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The held item moves on when the result register is free or being read.
    assign advance       = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            item_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_in;
        end
    end

    blm_datapath u_datapath (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Monitor state is updated once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // Pack the result item.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            result_reg.start_conversion,
                            result_reg.charged,
                            result_reg.charging,
                            result_reg.level_pct,
                            result_reg.voltage_mv,
                            result_reg.current_ma};

endmodule

`default_nettype wire

// File: hdl/blm_checker.sv
// ----------------------------------------------------------------------------
// Battery level monitor checker
// Port-level assertions on the monitor top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            cfg_we,
    input wire [blm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input wire [blm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire [blm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input wire                            s_axis_tuser,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [blm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import blm_pkg::*;

    logic               s_accept;
    logic [LEVEL_W-1:0] level;
    logic               cfg_seen;
    logic               in_seen;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign level    = m_axis_tdata[33:27];
    // Configuration and input contents do not bear on these checks.
    assign cfg_seen = cfg_we ^ (|cfg_index) ^ (|cfg_data);
    assign in_seen  = s_axis_tuser ^ (|s_axis_tdata);

    // A clock edge taken in reset leaves no result on offer.
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid after a reset edge");

    // With the result register empty the block must take an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty result register");

    // An accepted item is followed by a result on offer.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> ##1 m_axis_tvalid)
        else $error("no result two cycles after an accepted item");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The level is always one of the table entries or zero.
    a_level_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (cfg_seen || !cfg_seen) && (in_seen || !in_seen) |->
        (level == 7'd0) || (level == 7'd5) || (level == 7'd10) ||
        (level == 7'd20) || (level == 7'd30) || (level == 7'd50) ||
        (level == 7'd70) || (level == 7'd80) || (level == 7'd90) ||
        (level == 7'd95) || (level == 7'd100))
        else $error("charge level outside the table");

endmodule

bind battery_level_monitor_unit blm_checker u_blm_checker (.*);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery level monitor testbench
// Sends ADC-done and poll items over the input stream. An independent
// predictor works out the reading for each accepted item, and every result
// item is checked field by field against the oldest pending reading. The
// run uses several reference and poll interval settings, a directed table
// first and then random items, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------

module testbench;

    import blm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 225;
    localparam int MAX_REPORTS = 10;

    // Charge level table: first threshold strictly exceeded wins.
    localparam int TABLE_MV [10] = '{4200, 4150, 4100, 4000, 3900,
                                     3800, 3700, 3600, 3500, 3400};
    localparam int TABLE_PCT [10] = '{100, 95, 90, 80, 70, 50, 30, 20, 10, 5};

    typedef enum
    {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_LONG_STALLS
    } rx_mode_t;

    // One row of the directed table: a register write or an item.
    typedef struct
    {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        in_item_t              item;
        bit                    typed;
        result_t               want;
    } bench_row_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Predicted monitor state and settings.
    logic [REF_W-1:0]      ref_setting      = REF_MV_RESET;
    logic [INTERVAL_W-1:0] interval_setting = INTERVAL_RESET;
    logic [CUR_W-1:0]      avg_ma           = '0;
    logic [VOLT_W-1:0]     volt_mv          = '0;
    logic [TICK_W-1:0]     tick_due         = '0;
    logic [LEVEL_W-1:0]    level            = '0;
    logic                  chg_flag         = 1'b0;
    logic                  full_flag        = 1'b0;

    result_t pending_readings [$];

    int cycle_count  = 0;
    int mismatches   = 0;
    int results_seen = 0;
    int adc_items    = 0;
    int poll_items   = 0;
    int fires        = 0;
    int reg_writes   = 0;
    int burst_left   = 0;

    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_stall     = 0;
    int       rx_tick      = 0;

    battery_level_monitor_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock and cycle count.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // The voltage in millivolts mapped to a charge level in percent.
    function automatic logic [LEVEL_W-1:0] level_for(input logic [VOLT_W-1:0] mv);
        for (int i = 0; i < 10; i++)
        begin
            if (int'(mv) > TABLE_MV[i])
            begin
                return LEVEL_W'(TABLE_PCT[i]);
            end
        end
        return '0;
    endfunction

    // Updates the predicted state with one item and returns the reading.
    function automatic result_t predict_reading(input in_item_t it);
        logic [63:0] scaled;
        logic [63:0] sum;
        result_t     r;
        r.start_conversion = 1'b0;
        if (it.opcode == OP_ADC_DONE)
        begin
            scaled = (64'(ref_setting) * 64'(it.current_sample)) >> ADC_BITS;
            if (scaled > 64'(CUR_MAX))
            begin
                scaled = 64'(CUR_MAX);
            end
            sum = (64'(avg_ma) * 64'd7 + scaled) >> 3;
            avg_ma = (sum > 64'(CUR_MAX)) ? CUR_MAX : sum[CUR_W-1:0];
            scaled = (64'd2 * 64'(ref_setting) * 64'(it.voltage_sample)) >> ADC_BITS;
            volt_mv = (scaled > 64'(VOLT_MAX)) ? VOLT_MAX : scaled[VOLT_W-1:0];
        end
        else
        begin
            chg_flag  = ~it.charge_pin_level;
            full_flag = ~it.standby_pin_level;
            if (it.tick_count > tick_due)
            begin
                tick_due           = it.tick_count + TICK_W'(interval_setting);
                r.start_conversion = 1'b1;
                level              = level_for(volt_mv);
            end
        end
        r.current_ma = avg_ma;
        r.voltage_mv = volt_mv;
        r.level_pct  = level;
        r.charging   = chg_flag;
        r.charged    = full_flag;
        return r;
    endfunction

    function automatic bench_row_t blank_row();
        bench_row_t r;
        r.is_write = 1'b0;
        r.reg_idx  = '0;
        r.reg_val  = '0;
        r.item     = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic bench_row_t poll_row(input logic [TICK_W-1:0] tick,
                                            input logic chg, input logic stby);
        bench_row_t r;
        r = blank_row();
        r.item.opcode            = OP_POLL;
        r.item.tick_count        = tick;
        r.item.charge_pin_level  = chg;
        r.item.standby_pin_level = stby;
        return r;
    endfunction

    function automatic bench_row_t adc_row(input logic [SAMPLE_W-1:0] cur,
                                           input logic [SAMPLE_W-1:0] volt);
        bench_row_t r;
        r = blank_row();
        r.item.opcode         = OP_ADC_DONE;
        r.item.current_sample = cur;
        r.item.voltage_sample = volt;
        return r;
    endfunction

    function automatic bench_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] val);
        bench_row_t r;
        r = blank_row();
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    // Sends one item in bursts with random gaps, then queues its reading.
    task automatic send_item(input in_item_t it, input bit typed, input result_t want);
        int      gap;
        result_t r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, it.standby_pin_level, it.charge_pin_level,
                          it.tick_count, it.voltage_sample, it.current_sample};
        s_axis_tuser  <= it.opcode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        r = predict_reading(it);
        pending_readings.push_back(typed ? want : r);
        if (it.opcode == OP_ADC_DONE)
        begin
            adc_items++;
        end
        else
        begin
            poll_items++;
        end
        if (r.start_conversion)
        begin
            fires++;
        end
    endtask

    // Stops sending and waits until every pending reading has come back.
    task automatic drain_readings();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_readings.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_REF_MV)
        begin
            ref_setting = val[REF_W-1:0];
        end
        else
        begin
            interval_setting = val[INTERVAL_W-1:0];
        end
        reg_writes++;
        @(posedge clk);
    endtask

    // Result checking and the receiver stall pattern.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.current_ma       = m_axis_tdata[12:0];
            got.voltage_mv       = m_axis_tdata[26:13];
            got.level_pct        = m_axis_tdata[33:27];
            got.charging         = m_axis_tdata[34];
            got.charged          = m_axis_tdata[35];
            got.start_conversion = m_axis_tdata[36];
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("testbench: result with no reading pending, tdata=%h",
                             m_axis_tdata);
                end
            end
            else
            begin
                want = pending_readings.pop_front();
                results_seen++;
                if (got.current_ma !== want.current_ma || got.voltage_mv !== want.voltage_mv
                    || got.level_pct !== want.level_pct || got.charging !== want.charging
                    || got.charged !== want.charged
                    || got.start_conversion !== want.start_conversion)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("testbench: reading %0d expected ma=%0d mv=%0d pct=%0d",
                                 results_seen, want.current_ma, want.voltage_mv,
                                 want.level_pct, " chg=%0b full=%0b conv=%0b",
                                 want.charging, want.charged, want.start_conversion);
                        $display("testbench: reading %0d actual   ma=%0d mv=%0d pct=%0d",
                                 results_seen, got.current_ma, got.voltage_mv,
                                 got.level_pct, " chg=%0b full=%0b conv=%0b",
                                 got.charging, got.charged, got.start_conversion);
                    end
                end
            end
        end

        // The receiver switches at random between stall patterns.
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(40, 300);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:
                m_axis_tready <= 1'b1;
            RX_COIN:
                m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_PERIODIC:
                m_axis_tready <= (rx_tick % 5 != 0);
            default:
            begin
                if (rx_stall > 0)
                begin
                    rx_stall--;
                    m_axis_tready <= 1'b0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    rx_stall = $urandom_range(1, 12);
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    // Timeout.
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench: timeout after %0d cycles", cycle_count);
        $display("testbench: done, errors");
        $finish;
    end

    // Stimulus: directed table, then random phases under varied settings.
    initial
    begin : stimulus
        bench_row_t            rows [$];
        bench_row_t            row;
        in_item_t              it;
        result_t               none;
        logic [CFG_DATA_W-1:0] ref_choice [NUM_PHASES];
        logic [CFG_DATA_W-1:0] interval_choice [NUM_PHASES];
        int                    pick;
        int                    span;
        int                    target;
        int                    aim;

        none = '0;

        // After reset: a poll at tick zero does not fire, pins high clear both flags.
        row = poll_row(32'd0, 1'b1, 1'b1);
        row.typed = 1'b1;
        row.want  = '{current_ma: 13'd0, voltage_mv: 14'd0, level_pct: 7'd0,
                      charging: 1'b0, charged: 1'b0, start_conversion: 1'b0};
        rows.push_back(row);
        row = poll_row(32'd1, 1'b0, 1'b0);
        row.typed = 1'b1;
        row.want  = '{current_ma: 13'd0, voltage_mv: 14'd0, level_pct: 7'd0,
                      charging: 1'b1, charged: 1'b1, start_conversion: 1'b1};
        rows.push_back(row);
        // Full-scale samples; the pins and tick count of an ADC item are ignored.
        row = adc_row(12'hFFF, 12'hFFF);
        row.item.tick_count = 32'hFFFF_FFFF;
        row.typed = 1'b1;
        row.want  = '{current_ma: 13'd412, voltage_mv: 14'd6598, level_pct: 7'd0,
                      charging: 1'b1, charged: 1'b1, start_conversion: 1'b0};
        rows.push_back(row);
        row = adc_row(12'h000, 12'h000);
        row.typed = 1'b1;
        row.want  = '{current_ma: 13'd360, voltage_mv: 14'd0, level_pct: 7'd0,
                      charging: 1'b1, charged: 1'b1, start_conversion: 1'b0};
        rows.push_back(row);
        // Poll that does not fire, then a fire whose next tick wraps past zero.
        rows.push_back(poll_row(32'd41, 1'b1, 1'b0));
        rows.push_back(poll_row(32'hFFFF_FFFF, 1'b0, 1'b1));
        rows.push_back(poll_row(32'd40, 1'b1, 1'b1));
        // With ref_mv 4096 the voltage is twice the sample: probe table edges.
        rows.push_back(write_row(REG_REF_MV, 16'd4096));
        rows.push_back(adc_row(12'd100, 12'd2100));
        rows.push_back(poll_row(32'd1000, 1'b0, 1'b1));
        rows.push_back(adc_row(12'd200, 12'd2101));
        rows.push_back(poll_row(32'd2000, 1'b1, 1'b0));
        rows.push_back(adc_row(12'd300, 12'd1700));
        rows.push_back(poll_row(32'd3000, 1'b0, 1'b0));
        rows.push_back(adc_row(12'd400, 12'd1701));
        rows.push_back(poll_row(32'd4000, 1'b1, 1'b1));
        // Largest reference, upper data bits set.
        rows.push_back(write_row(REG_REF_MV, 16'hFFFF));
        rows.push_back(adc_row(12'hFFF, 12'hFFF));
        // Zero poll interval: the same tick must not fire twice.
        rows.push_back(write_row(REG_POLL_INTERVAL, 16'd0));
        rows.push_back(poll_row(32'd5000, 1'b0, 1'b0));
        rows.push_back(poll_row(32'd5000, 1'b1, 1'b1));
        rows.push_back(poll_row(32'd5001, 1'b0, 1'b1));
        // Largest interval near the top of the tick range.
        rows.push_back(write_row(REG_POLL_INTERVAL, 16'hFFFF));
        rows.push_back(poll_row(32'hFFFF_FFFE, 1'b1, 1'b0));
        rows.push_back(poll_row(32'h0001_0000, 1'b0, 1'b0));

        ref_choice      = '{16'd3300, 16'd1000, 16'd5000, 16'h0000, 16'hE7A3, 16'd0};
        interval_choice = '{16'd40, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0};
        ref_choice[5]      = 16'($urandom);
        interval_choice[4] = 16'($urandom_range(1, 200));
        interval_choice[5] = 16'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].is_write)
            begin
                drain_readings();
                write_register(rows[i].reg_idx, rows[i].reg_val);
            end
            else
            begin
                send_item(rows[i].item, rows[i].typed, rows[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_readings();
            write_register(REG_REF_MV, ref_choice[p]);
            write_register(REG_POLL_INTERVAL, interval_choice[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it = '0;
                it.current_sample    = 12'($urandom);
                it.voltage_sample    = 12'($urandom);
                it.tick_count        = $urandom;
                it.charge_pin_level  = 1'($urandom);
                it.standby_pin_level = 1'($urandom);
                pick = $urandom_range(0, 9);
                if ($urandom_range(0, 1) == 0)
                begin
                    it.opcode = OP_ADC_DONE;
                    // Aim many voltages into the band that the level table covers.
                    if (pick < 4 && ref_setting != 0)
                    begin
                        target = $urandom_range(3300, 4300);
                        aim = (target * 4096 + 2 * int'(ref_setting) - 1)
                              / (2 * int'(ref_setting));
                        it.voltage_sample = (aim > 4095) ? 12'hFFF : 12'(aim);
                    end
                    else if (pick == 4)
                    begin
                        it.current_sample = ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000;
                        it.voltage_sample = ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000;
                    end
                end
                else
                begin
                    it.opcode = OP_POLL;
                    span = int'(interval_setting) / 2 + 2;
                    // Most polls land around the next due tick so that about half fire.
                    if (pick < 6)
                    begin
                        it.tick_count = tick_due + 32'($urandom_range(0, span))
                                        - 32'($urandom_range(0, span));
                    end
                    else if (pick == 6)
                    begin
                        it.tick_count = tick_due;
                    end
                    else if (pick == 7)
                    begin
                        it.tick_count = tick_due + 32'd1;
                    end
                    else if (pick == 8)
                    begin
                        it.tick_count = 32'hFFFF_FFFF - 32'($urandom_range(0, 70000));
                    end
                end
                send_item(it, 1'b0, none);
            end
        end

        drain_readings();
        repeat (8) @(posedge clk);
        $display("testbench: %0d ADC items and %0d polls (%0d conversion requests), %0d register writes",
                 adc_items, poll_items, fires, reg_writes);
        $display("testbench: %0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && pending_readings.size() == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
